@@ rtl/sle_pkg.sv @@
// Shared types, sizes and codes for the serial line editor.
package sle_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int TX_DEPTH   = 32;
  localparam int Q_DEPTH    = 2;

  localparam int LC_W = $clog2(LINE_DEPTH + 1);
  localparam int LI_W = $clog2(LINE_DEPTH);
  localparam int TC_W = $clog2(TX_DEPTH + 1);
  localparam int TI_W = $clog2(TX_DEPTH);
  localparam int QC_W = $clog2(Q_DEPTH + 1);
  localparam int QI_W = $clog2(Q_DEPTH);

  typedef logic [7:0]      char_t;
  typedef logic [LC_W-1:0] line_cnt_t;
  typedef logic [LI_W-1:0] line_idx_t;
  typedef logic [TC_W-1:0] tx_cnt_t;
  typedef logic [TI_W-1:0] tx_idx_t;

  localparam char_t CH_BS  = 8'd8;
  localparam char_t CH_DEL = 8'd127;
  localparam char_t CH_CR  = 8'd13;
  localparam char_t CH_LF  = 8'd10;

  localparam line_cnt_t LINE_FULL = LC_W'(LINE_DEPTH);
  localparam tx_cnt_t   TX_FULL   = TC_W'(TX_DEPTH);

  typedef enum logic [1:0] {
    CMD_RX   = 2'd0,
    CMD_READ = 2'd1,
    CMD_TXWR = 2'd2,
    CMD_TAKE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_RX_EDIT = 3'd0,
    OP_RX_CHAR = 3'd1,
    OP_RX_CR   = 3'd2,
    OP_READ    = 3'd3,
    OP_TX_WR   = 3'd4,
    OP_TX_TAKE = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    op_t   op;
    char_t data;
  } item_t;

endpackage

@@ rtl/sle_ifs.sv @@
// Valid/ready channel interfaces for command items and result items.
interface sle_in_if;
  logic         valid;
  logic         ready;
  logic [1:0]   cmd;
  logic [7:0]   data;

  modport source (output valid, output cmd, output data, input ready);
  modport sink   (input valid, input cmd, input data, output ready);
endinterface

interface sle_out_if;
  logic         valid;
  logic         ready;
  logic [1:0]   status;
  logic [7:0]   out_char;
  logic         last;
  logic         line_ready;
  logic [5:0]   line_count;
  logic [5:0]   tx_fill;

  modport source (output valid, output status, output out_char, output last,
                  output line_ready, output line_count, output tx_fill, input ready);
  modport sink   (input valid, input status, input out_char, input last,
                  input line_ready, input line_count, input tx_fill, output ready);
endinterface

@@ rtl/sle_front.sv @@
// Input stage: accepts command items and classifies them into operations.
module sle_front (
  input  logic          clk,
  input  logic          rst_n,
  sle_in_if.sink        in_if,
  output logic          push_valid,
  output sle_pkg::item_t push_item,
  input  logic          push_ready
);
  import sle_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  take;

  assign in_if.ready = !valid_r || push_ready;
  assign take        = in_if.valid && in_if.ready;
  assign push_valid  = valid_r;
  assign push_item   = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (push_ready) begin
      valid_nxt = 1'b0;
    end
    if (take) begin
      valid_nxt     = 1'b1;
      item_nxt.data = in_if.data;
      case (cmd_t'(in_if.cmd))
        CMD_RX: begin
          if (in_if.data == CH_BS || in_if.data == CH_DEL) begin
            item_nxt.op = OP_RX_EDIT;
          end else if (in_if.data == CH_CR) begin
            item_nxt.op = OP_RX_CR;
          end else begin
            item_nxt.op = OP_RX_CHAR;
          end
        end
        CMD_READ: item_nxt.op = OP_READ;
        CMD_TXWR: item_nxt.op = OP_TX_WR;
        CMD_TAKE: item_nxt.op = OP_TX_TAKE;
        default:  item_nxt.op = OP_TX_TAKE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

@@ rtl/sle_queue.sv @@
// Short FIFO of classified items between the front and back stages.
module sle_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  sle_pkg::item_t push_item,
  output logic           push_ready,
  output logic           pop_valid,
  output sle_pkg::item_t pop_item,
  input  logic           pop_ready
);
  import sle_pkg::*;

  item_t           slots_r [Q_DEPTH];
  logic [QI_W-1:0] wr_r, wr_nxt;
  logic [QI_W-1:0] rd_r, rd_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = cnt_r != QC_W'(Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = slots_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == QI_W'(Q_DEPTH - 1)) ? '0 : wr_r + QI_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == QI_W'(Q_DEPTH - 1)) ? '0 : rd_r + QI_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + QC_W'(1);
      2'b01:   cnt_nxt = cnt_r - QC_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      slots_r[wr_r] <= push_item;
    end
  end

endmodule

@@ rtl/sle_back.sv @@
// Execution stage: line buffer, transmit ring and registered result item.
module sle_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  input  sle_pkg::item_t pop_item,
  output logic           pop_ready,
  sle_out_if.source      out_if
);
  import sle_pkg::*;

  char_t     line_store_r [LINE_DEPTH];
  char_t     tx_ring_r [TX_DEPTH];
  line_cnt_t len_r, len_nxt;
  line_cnt_t rp_r, rp_nxt;
  logic      done_r, done_nxt;
  tx_idx_t   head_r, head_nxt;
  tx_cnt_t   cnt_r, cnt_nxt;

  logic      out_valid_r, out_valid_nxt;
  status_t   status_r, status_nxt;
  char_t     ochar_r, ochar_nxt;
  logic      last_r, last_nxt;
  logic      fire;

  logic      store_we;
  logic      ring_we0, ring_we1;
  tx_idx_t   tail0, tail1;
  line_cnt_t rp_inc;

  function automatic tx_idx_t tx_wrap(input logic [TC_W:0] s);
    logic [TC_W:0] r;
    r = (s >= (TC_W + 1)'(TX_DEPTH)) ? s - (TC_W + 1)'(TX_DEPTH) : s;
    return TI_W'(r);
  endfunction

  assign pop_ready = !out_valid_r || out_if.ready;
  assign fire      = pop_valid && pop_ready;
  assign tail0     = tx_wrap((TC_W + 1)'(head_r) + (TC_W + 1)'(cnt_r));
  assign tail1     = tx_wrap((TC_W + 1)'(tail0) + (TC_W + 1)'(1));
  assign rp_inc    = rp_r + LC_W'(1);

  always_comb begin
    len_nxt    = len_r;
    rp_nxt     = rp_r;
    done_nxt   = done_r;
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    ochar_nxt  = '0;
    last_nxt   = 1'b0;
    store_we   = 1'b0;
    ring_we0   = 1'b0;
    ring_we1   = 1'b0;
    if (fire) begin
      case (pop_item.op)
        OP_RX_EDIT, OP_RX_CHAR, OP_RX_CR: begin
          if (done_r) begin
            status_nxt = ST_REFUSED;
          end else begin
            if (pop_item.op == OP_RX_EDIT) begin
              if (len_r != '0) begin
                len_nxt = len_r - LC_W'(1);
              end
            end else if (len_r < LINE_FULL) begin
              store_we = 1'b1;
              len_nxt  = len_r + LC_W'(1);
            end else begin
              status_nxt = ST_FULL;
            end
            // echo, plus line feed after carriage return when room remains
            if (cnt_r < TX_FULL) begin
              ring_we0 = 1'b1;
              cnt_nxt  = cnt_r + TC_W'(1);
              if (pop_item.op == OP_RX_CR && cnt_r + TC_W'(1) < TX_FULL) begin
                ring_we1 = 1'b1;
                cnt_nxt  = cnt_r + TC_W'(2);
              end
            end
            if (len_nxt >= LINE_FULL || pop_item.op == OP_RX_CR) begin
              done_nxt = 1'b1;
            end
          end
        end
        OP_READ: begin
          if (rp_r < len_r) begin
            ochar_nxt = line_store_r[rp_r[LI_W-1:0]];
            rp_nxt    = rp_inc;
            if (rp_inc == len_r) begin
              last_nxt = 1'b1;
              len_nxt  = '0;
              rp_nxt   = '0;
              done_nxt = 1'b0;
            end
          end else begin
            status_nxt = ST_EMPTY;
            len_nxt    = '0;
            rp_nxt     = '0;
            done_nxt   = 1'b0;
          end
        end
        OP_TX_WR: begin
          if (cnt_r < TX_FULL) begin
            ring_we0 = 1'b1;
            cnt_nxt  = cnt_r + TC_W'(1);
          end else begin
            status_nxt = ST_FULL;
          end
        end
        OP_TX_TAKE: begin
          if (cnt_r != '0) begin
            ochar_nxt = tx_ring_r[head_r];
            head_nxt  = tx_wrap((TC_W + 1)'(head_r) + (TC_W + 1)'(1));
            cnt_nxt   = cnt_r - TC_W'(1);
          end else begin
            status_nxt = ST_EMPTY;
          end
        end
        default: status_nxt = ST_OK;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      rp_r        <= '0;
      done_r      <= 1'b0;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      rp_r        <= rp_nxt;
      done_r      <= done_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (fire) begin
      status_r <= status_nxt;
      ochar_r  <= ochar_nxt;
      last_r   <= last_nxt;
    end
    if (store_we) begin
      line_store_r[len_r[LI_W-1:0]] <= pop_item.data;
    end
    if (ring_we0) begin
      tx_ring_r[tail0] <= pop_item.data;
    end
    if (ring_we1) begin
      tx_ring_r[tail1] <= CH_LF;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = status_r;
  assign out_if.out_char   = ochar_r;
  assign out_if.last       = last_r;
  assign out_if.line_ready = done_r;
  assign out_if.line_count = 6'(len_r);
  assign out_if.tx_fill    = 6'(cnt_r);

endmodule

@@ rtl/serial_line_editor_with_echo_core.sv @@
// Top level of the serial line editor with echo.
// Usage:
//   in_if  carries command items (cmd, data) on valid/ready. cmd selects a
//          received character, a line character read, a software write to
//          the transmit ring, or a take by the transmitter.
//   out_if returns exactly one result item per command item, in order:
//          status, out_char, last, and the line and ring fill after it.
// Timing:
//   One item per cycle sustained while out_if.ready is high. An accepted item
//   reaches out_if through the front register, the queue and the result register.
//   The line buffer and ring update in the back stage as it takes each item.
// Stall:
//   A stalled out_if holds its result; the two-entry queue and the front
//   register absorb further items before in_if.ready drops.
// Reset:
//   Synchronous, active low. Line empty, no line pending, ring empty.
//   Buffer contents are not cleared.
module serial_line_editor_with_echo_core (
  input  logic      clk,
  input  logic      rst_n,
  sle_in_if.sink    in_if,
  sle_out_if.source out_if
);
  import sle_pkg::*;

  logic  f_valid, f_ready;
  item_t f_item;
  logic  q_valid, q_ready;
  item_t q_item;

  sle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .push_valid (f_valid),
    .push_item  (f_item),
    .push_ready (f_ready)
  );

  sle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_item  (f_item),
    .push_ready (f_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_ready  (q_ready)
  );

  sle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_valid),
    .pop_item  (q_item),
    .pop_ready (q_ready),
    .out_if    (out_if)
  );

endmodule
